// ----- src/great_circle_distance_assert.svh -----
// ----------------------------------------------------------------------------
// great_circle_distance_assert
// assertion macros shared by the block
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// same-cycle implication
`define GCD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("great_circle_distance assertion failed");

// next-cycle implication
`define GCD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("great_circle_distance assertion failed");

`endif

// ----- src/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// gcd_pkg
// constants, tables and helpers of the great-circle distance pipeline
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int ANGLE_FRACTION_BITS = 23;

	localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int DROP = 23 - ANGLE_FRACTION_BITS;
	localparam logic [32:0] QMASK = ~((33'd1 << DROP) - 33'd1);

	// datapath widths: trig values, vectoring x/y
	localparam int RW = 34;
	localparam int AW = 36;

	localparam logic [31:0] GAIN_INV = 32'h26DD3B6A;
	localparam logic [31:0] HALF_PI = 32'd1686629713;
	localparam logic [31:0] PI_RAD_K = 32'hC90FDAA2;
	// ceil(2^45 / 45), exact floor division of 39-bit values by 45
	localparam logic [39:0] RECIP45 = 40'd781874935308;
	localparam logic [22:0] RADIUS_RESET = 23'd6372795;

	localparam logic REG_RADIUS = 1'b0;

	localparam int SC_LAT = STEPS + 5;
	localparam int SQ_LAT = 32;
	localparam int AT_LAT = STEPS + 1;
	localparam int LAT = 1 + SC_LAT + 4 + SQ_LAT + AT_LAT + 2;

	localparam logic [31:0] ATAN_TAB [0:31] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// q30 product, floored
	function automatic logic signed [RW-1:0] mul30(input logic signed [RW-1:0] a,
			input logic signed [RW-1:0] b);
		logic signed [2*RW-1:0] p;
		p = a * b;
		return RW'(p >>> 30);
	endfunction

endpackage

// ----- src/gcd_sincos.sv -----
// ----------------------------------------------------------------------------
// gcd_sincos
// degrees to binary angle, quadrant fold and unrolled rotation cordic
// ----------------------------------------------------------------------------
module gcd_sincos import gcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [32:0]   deg,
	output logic                 out_valid,
	output logic signed [RW-1:0] cos_out,
	output logic signed [RW-1:0] sin_out
);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [38:0]       u_s1;
	logic              neg_s1, neg_s2;
	logic [58:0]       pph_s2;
	logic [59:0]       ppl_s2;
	logic signed [31:0] r_s3;
	logic              flip_s3;

	logic signed [39:0] n40;
	logic signed [39:0] u40;
	logic [79:0]       prod80;
	logic [31:0]       q32;
	logic [31:0]       ba;
	logic              flip;
	logic signed [64:0] zprod;

	logic signed [RW-1:0] cx_s [0:STEPS];
	logic signed [RW-1:0] cy_s [0:STEPS];
	logic signed [RW-1:0] cz_s [0:STEPS];
	logic                 cf_s [0:STEPS];
	logic                 cv_s [0:STEPS];

	always_comb begin
		n40 = $signed({deg[32], deg, 6'b0});
		u40 = n40[39] ? (40'sd44 - n40) : n40;
		prod80 = {1'b0, pph_s2, 20'b0} + {20'b0, ppl_s2};
		q32 = prod80[76:45];
		ba = neg_s2 ? (32'd0 - q32) : q32;
		flip = ba[31] ^ ba[30];
		zprod = r_s3 * $signed({1'b0, PI_RAD_K});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		u_s1 <= u40[38:0];
		neg_s1 <= n40[39];
		pph_s2 <= u_s1[38:20] * RECIP45;
		ppl_s2 <= u_s1[19:0] * RECIP45;
		neg_s2 <= neg_s1;
		r_s3 <= $signed({ba[31] ^ flip, ba[30:0]});
		flip_s3 <= flip;
		cz_s[0] <= RW'(zprod >>> 31);
		cx_s[0] <= $signed({{(RW-32){1'b0}}, GAIN_INV});
		cy_s[0] <= '0;
		cf_s[0] <= flip_s3;
	end

	assign cv_s[0] = v_s4;

	for (genvar i = 0; i < STEPS; i++) begin : g_stage
		logic signed [RW-1:0] xs, ys, at;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;
		assign at = $signed({{(RW-32){1'b0}}, ATAN_TAB[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!cz_s[i][RW-1]) begin
				cx_s[i+1] <= cx_s[i] - ys;
				cy_s[i+1] <= cy_s[i] + xs;
				cz_s[i+1] <= cz_s[i] - at;
			end else begin
				cx_s[i+1] <= cx_s[i] + ys;
				cy_s[i+1] <= cy_s[i] - xs;
				cz_s[i+1] <= cz_s[i] + at;
			end
			cf_s[i+1] <= cf_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= cv_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		cos_out <= cf_s[STEPS] ? -cx_s[STEPS] : cx_s[STEPS];
		sin_out <= cf_s[STEPS] ? -cy_s[STEPS] : cy_s[STEPS];
	end

endmodule

// ----- src/gcd_isqrt.sv -----
// ----------------------------------------------------------------------------
// gcd_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module gcd_isqrt import gcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [63:0]          radicand,
	input  logic signed [RW-1:0] side_in,
	output logic                 out_valid,
	output logic [31:0]          root,
	output logic signed [RW-1:0] side_out
);

	logic [63:0]          rem_s  [0:32];
	logic [63:0]          res_s  [0:32];
	logic signed [RW-1:0] side_s [0:32];
	logic                 v_s    [0:32];

	assign rem_s[0] = radicand;
	assign res_s[0] = '0;
	assign side_s[0] = side_in;
	assign v_s[0] = in_valid;

	for (genvar k = 0; k < 32; k++) begin : g_stage
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = res_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_s[k] >= trial) begin
				rem_s[k+1] <= rem_s[k] - trial;
				res_s[k+1] <= (res_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1] <= rem_s[k];
				res_s[k+1] <= res_s[k] >> 1;
			end
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = v_s[32];
	assign root = res_s[32][31:0];
	assign side_out = side_s[32];

endmodule

// ----- src/gcd_atan2.sv -----
// ----------------------------------------------------------------------------
// gcd_atan2
// half-plane fold and unrolled vectoring cordic
// ----------------------------------------------------------------------------
module gcd_atan2 import gcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [31:0]          y_in,
	input  logic signed [RW-1:0] x_in,
	output logic                 out_valid,
	output logic signed [RW-1:0] angle
);

	logic signed [AW-1:0] vx_s [0:STEPS];
	logic signed [AW-1:0] vy_s [0:STEPS];
	logic signed [RW-1:0] vz_s [0:STEPS];
	logic                 vv_s [0:STEPS];

	logic signed [AW-1:0] xe, ye;

	assign xe = AW'(x_in);
	assign ye = $signed({{(AW-32){1'b0}}, y_in});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv_s[0] <= 1'b0;
		end else begin
			vv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (xe[AW-1]) begin
			vx_s[0] <= ye;
			vy_s[0] <= -xe;
			vz_s[0] <= $signed({{(RW-32){1'b0}}, HALF_PI});
		end else begin
			vx_s[0] <= xe;
			vy_s[0] <= ye;
			vz_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_stage
		logic signed [AW-1:0] xs, ys;
		logic signed [RW-1:0] at;
		assign xs = vx_s[i] >>> i;
		assign ys = vy_s[i] >>> i;
		assign at = $signed({{(RW-32){1'b0}}, ATAN_TAB[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[i+1] <= 1'b0;
			end else begin
				vv_s[i+1] <= vv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!vy_s[i][AW-1]) begin
				vx_s[i+1] <= vx_s[i] + ys;
				vy_s[i+1] <= vy_s[i] - xs;
				vz_s[i+1] <= vz_s[i] + at;
			end else begin
				vx_s[i+1] <= vx_s[i] - ys;
				vy_s[i+1] <= vy_s[i] + xs;
				vz_s[i+1] <= vz_s[i] - at;
			end
		end
	end

	assign out_valid = vv_s[STEPS];
	assign angle = vz_s[STEPS];

endmodule

// ----- src/great_circle_distance.sv -----
// ----------------------------------------------------------------------------
// great_circle_distance
// great-circle distance between two points, spherical vincenty, fixed point
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle that start is high; busy never rises.
// Each result leaves for one cycle with done high and cannot be held off. The
// result passes through the two unrolled cordic chains and the 32-stage square
// root.
`include "great_circle_distance_assert.svh"

module great_circle_distance import gcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	output logic [24:0]        distance_m,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [22:0] radius_q;

	logic               v_s1;
	logic signed [32:0] lat1_s1, lat2_s1, dlon_s1;
	logic signed [32:0] lat1_q, lat2_q, lon1_q, lon2_q;

	logic                 sc_v;
	logic signed [RW-1:0] cl1, sl1, cl2, sl2, cd, sd;

	logic                 v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [RW-1:0] a_s2, p1_s2, p2_s2, p3_s2, p4_s2, cd_s2;
	logic signed [RW-1:0] a_s3, b_s3, c_s3;
	logic [63:0]          aa_s4, bb_s4;
	logic signed [RW-1:0] c_s4, c_s5;
	logic [63:0]          sum_s5;

	logic                 sq_v;
	logic [31:0]          sq_root;
	logic signed [RW-1:0] sq_c;

	logic                 at_v;
	logic signed [RW-1:0] ang;
	logic [31:0]          ang_pos;
	logic [54:0]          prod_s6;
	logic [55:0]          rnd;
	logic [24:0]          dist_s7;

	logic signed [2*RW-1:0] aa_full, bb_full;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIUS) ? {9'b0, radius_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
			radius_q <= pwdata[22:0];
		end
	end

	assign busy = 1'b0;

	// input stage, quantized angles and longitude difference
	always_comb begin
		lat1_q = $signed({{2{first_latitude[30]}}, first_latitude}) & $signed(QMASK);
		lat2_q = $signed({{2{second_latitude[30]}}, second_latitude}) & $signed(QMASK);
		lon1_q = $signed({first_longitude[31], first_longitude}) & $signed(QMASK);
		lon2_q = $signed({second_longitude[31], second_longitude}) & $signed(QMASK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		lat1_s1 <= lat1_q;
		lat2_s1 <= lat2_q;
		dlon_s1 <= lon2_q - lon1_q;
	end

	gcd_sincos u_sc_lat1 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .deg(lat1_s1),
		.out_valid(sc_v), .cos_out(cl1), .sin_out(sl1)
	);

	gcd_sincos u_sc_lat2 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .deg(lat2_s1),
		.out_valid(), .cos_out(cl2), .sin_out(sl2)
	);

	gcd_sincos u_sc_dlon (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .deg(dlon_s1),
		.out_valid(), .cos_out(cd), .sin_out(sd)
	);

	// a, b, c and the squares of a and b
	assign aa_full = a_s3 * a_s3;
	assign bb_full = b_s3 * b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= sc_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		a_s2 <= mul30(cl2, sd);
		p1_s2 <= mul30(cl1, sl2);
		p2_s2 <= mul30(sl1, cl2);
		p3_s2 <= mul30(sl1, sl2);
		p4_s2 <= mul30(cl1, cl2);
		cd_s2 <= cd;
		a_s3 <= a_s2;
		b_s3 <= p1_s2 - mul30(p2_s2, cd_s2);
		c_s3 <= p3_s2 + mul30(p4_s2, cd_s2);
		aa_s4 <= aa_full[63:0];
		bb_s4 <= bb_full[63:0];
		c_s4 <= c_s3;
		sum_s5 <= aa_s4 + bb_s4;
		c_s5 <= c_s4;
	end

	gcd_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5), .radicand(sum_s5), .side_in(c_s5),
		.out_valid(sq_v), .root(sq_root), .side_out(sq_c)
	);

	gcd_atan2 u_atan2 (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_v), .y_in(sq_root), .x_in(sq_c),
		.out_valid(at_v), .angle(ang)
	);

	// radius scaling and rounding
	assign ang_pos = ang[RW-1] ? 32'd0 : ang[31:0];
	assign rnd = {1'b0, prod_s6} + (56'd1 << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s6 <= at_v;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		prod_s6 <= ang_pos * radius_q;
		dist_s7 <= rnd[54:30];
	end

	assign done = v_s7;
	assign distance_m = dist_s7;

	`GCD_ASSERT_IMP(done_follows_start_a, done, $past(start && !busy, LAT))
	`GCD_ASSERT_NXT(radius_write_a, psel && penable && pwrite && paddr[2] == REG_RADIUS, radius_q == $past(pwdata[22:0]))

endmodule
